// ===== rtl/mono_framebuffer_text_draw_defines.svh =====
// ----------------------------------------------------------------------------
// mono_framebuffer_text_draw_defines.svh
// Assertion macros for the framebuffer text draw block.
// ----------------------------------------------------------------------------
`ifndef MONO_FRAMEBUFFER_TEXT_DRAW_DEFINES_SVH
`define MONO_FRAMEBUFFER_TEXT_DRAW_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define MFBTD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define MFBTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mfbtd_pkg.sv =====
// ----------------------------------------------------------------------------
// mfbtd_pkg
// Types, codes and the 5x7 font shared by the framebuffer text draw block.
// ----------------------------------------------------------------------------
`default_nettype none

package mfbtd_pkg;

  typedef enum logic [2:0] {
    OP_PIXEL  = 3'd0,
    OP_CURSOR = 3'd1,
    OP_CHAR   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_FILL   = 3'd4,
    OP_READ   = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic       pixel_color;
    logic [7:0] char_code;
    logic [9:0] byte_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_STEP_RD,
    ST_STEP_WR,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic sweep_wr;
    logic sweep_fill;
    logic step_rd;
    logic step_wr;
    logic step_next;
    logic read_rd;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       step_valid;
    logic       step_last;
    logic       sweep_last;
  } dp_status_t;

  localparam logic [7:0] CURSOR_ADVANCE = 8'd6;
  localparam logic [7:0] BYTE_SET       = 8'hFF;
  localparam logic [7:0] BYTE_CLEAR     = 8'h00;
  localparam int         GLYPH_COLS     = 5;
  localparam int         GLYPH_ROWS     = 7;

  // first column in the top byte; unknown codes are blank
  function automatic logic [39:0] glyph_bits(input logic [7:0] code);
    logic [39:0] bits;
    case (code)
      8'h41:   bits = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
      8'h43:   bits = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
      8'h44:   bits = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
      8'h56:   bits = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      8'h6D:   bits = {8'h7C, 8'h04, 8'h18, 8'h04, 8'h78};
      8'h3A:   bits = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
      8'h30:   bits = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
      8'h31:   bits = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      8'h32:   bits = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      8'h33:   bits = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      8'h34:   bits = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      8'h35:   bits = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      8'h36:   bits = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
      8'h37:   bits = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      8'h38:   bits = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      8'h39:   bits = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
      8'h45:   bits = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
      8'h4D:   bits = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      8'h4F:   bits = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      8'h50:   bits = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
      8'h52:   bits = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
      8'h53:   bits = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
      8'h54:   bits = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      default: bits = '0;
    endcase
    return bits;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mono_framebuffer_text_draw.sv =====
// ----------------------------------------------------------------------------
// mono_framebuffer_text_draw
// Page-organized monochrome framebuffer with pixel, text and readback items.
// ----------------------------------------------------------------------------
// Input channel item_valid/item_stall/item carries one command transaction;
// output channel result_valid/result_stall/result returns exactly one result
// transaction per command: read byte (zero unless an in-range read), cursor.
// One command is in work at a time; item_stall is low only when idle.
// Store work per command, through the RAM's write and read ports:
//   cursor set, unused code: none; read byte: one read; pixel: one
//   read-modify-write, skipped off the panel; character: 5 columns x 2 page
//   passes, read-modify-write for passes with lit pixels, a skip for the others
//   clear or fill: every byte written, one byte per cycle
// After reset the store is swept to zero, one byte per cycle, over all
// PANEL_WIDTH*ceil(PANEL_HEIGHT/8) bytes (1024 by default); item_stall is
// high during that sweep. The cursor resets to (0, 0).
// A finished result sits in the output register; while result_stall holds
// it there the block can still accept and work one more command, which then
// waits for the output register to empty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mono_framebuffer_text_draw_defines.svh"

module mono_framebuffer_text_draw #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire mfbtd_pkg::in_item_t  item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output mfbtd_pkg::out_item_t      result
);

  import mfbtd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mfbtd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_op      (item.operation),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status)
  );

  mfbtd_dp #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

  `MFBTD_ASSERT_NOW(a_wr_after_rd, cmd.step_wr, $past(cmd.step_rd), "write without read")
  `MFBTD_ASSERT_NOW(a_one_writer, 1'b1, $onehot0({cmd.sweep_wr, cmd.step_wr}), "two writers")
  `MFBTD_ASSERT_NOW(a_sweep_busy, cmd.sweep_wr, item_stall, "accept during sweep")
  `MFBTD_ASSERT_NEXT(a_busy_after_acc, item_valid && !item_stall, item_stall, "double accept")

endmodule

`default_nettype wire

// ===== rtl/mfbtd_ram.sv =====
// ----------------------------------------------------------------------------
// mfbtd_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mfbtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mfbtd_ctrl.sv =====
// ----------------------------------------------------------------------------
// mfbtd_ctrl
// Sequencer: init sweep, item dispatch, read-modify-write steps, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module mfbtd_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  input  wire logic [2:0]             item_op,
  output logic                        item_stall,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output mfbtd_pkg::ctrl_cmd_t        cmd,
  input  wire mfbtd_pkg::dp_status_t  status
);

  import mfbtd_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign item_stall = (state != ST_IDLE);
  assign out_free   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (status.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_valid) begin
          case (item_op)
            OP_PIXEL, OP_CHAR: state_next = ST_STEP_RD;
            OP_CLEAR, OP_FILL: state_next = ST_SWEEP;
            OP_READ:           state_next = ST_READ;
            default:           state_next = ST_DONE;
          endcase
        end
      end
      ST_SWEEP: begin
        if (status.sweep_last) state_next = ST_DONE;
      end
      ST_STEP_RD: begin
        if (status.step_valid) state_next = ST_STEP_WR;
        else if (status.step_last) state_next = ST_DONE;
      end
      ST_STEP_WR: begin
        state_next = status.step_last ? ST_DONE : ST_STEP_RD;
      end
      ST_READ: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_INIT: cmd.sweep_wr = 1'b1;
      ST_IDLE: cmd.latch = item_valid;
      ST_SWEEP: begin
        cmd.sweep_wr   = 1'b1;
        cmd.sweep_fill = (status.op == OP_FILL);
      end
      ST_STEP_RD: begin
        cmd.step_rd   = status.step_valid;
        cmd.step_next = !status.step_valid && !status.step_last;
      end
      ST_STEP_WR: begin
        cmd.step_wr   = 1'b1;
        cmd.step_next = !status.step_last;
      end
      ST_READ: cmd.read_rd = 1'b1;
      ST_DONE: cmd.finish = out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mfbtd_dp.sv =====
// ----------------------------------------------------------------------------
// mfbtd_dp
// Datapath: item and cursor registers, glyph masks, store RAM, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mfbtd_dp #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire mfbtd_pkg::in_item_t   item,
  input  wire mfbtd_pkg::ctrl_cmd_t  cmd,
  output mfbtd_pkg::dp_status_t      status,
  output mfbtd_pkg::out_item_t       result
);

  import mfbtd_pkg::*;

  localparam int PAGE_COUNT = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_USED = PANEL_WIDTH * PAGE_COUNT;
  localparam int ADDR_W     = $clog2(STORE_USED);

  in_item_t          cur;
  logic [7:0]        text_col;
  logic [7:0]        text_row;
  logic [7:0]        col_next;
  logic [7:0]        row_next;
  logic [2:0]        col_cnt;
  logic              pass_q;
  logic [ADDR_W-1:0] sweep_cnt;
  logic              sweep_last;

  logic [39:0]       gbits;
  logic [2:0]        gsel;
  logic [7:0]        gcol;
  logic [7:0]        text_row_end;
  logic [4:0]        char_page;
  logic [7:0]        char_mask;

  logic [7:0]        step_x;
  logic [4:0]        step_page;
  logic [7:0]        step_mask;
  logic              step_valid;
  logic [ADDR_W-1:0] step_addr;
  logic              is_pixel;
  logic              is_char;
  logic              rd_in_range;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic [7:0]        rmw_data;

  assign is_pixel   = (cur.operation == OP_PIXEL);
  assign is_char    = (cur.operation == OP_CHAR);
  assign sweep_last = (sweep_cnt == ADDR_W'(STORE_USED - 1));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur <= item;
    end
    if (cmd.finish) begin
      result.read_data  <= (cur.operation == OP_READ && rd_in_range) ? ram_rdata : BYTE_CLEAR;
      result.cursor_col <= col_next;
      result.cursor_row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_col  <= '0;
      text_row  <= '0;
      col_cnt   <= '0;
      pass_q    <= 1'b0;
      sweep_cnt <= '0;
    end else begin
      if (cmd.finish) begin
        text_col <= col_next;
        text_row <= row_next;
      end
      if (cmd.latch) begin
        col_cnt <= '0;
        pass_q  <= 1'b0;
      end else if (cmd.step_next) begin
        pass_q <= !pass_q;
        if (pass_q) col_cnt <= col_cnt + 3'd1;
      end
      if (cmd.sweep_wr) begin
        sweep_cnt <= sweep_last ? '0 : sweep_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    col_next = text_col;
    row_next = text_row;
    if (cur.operation == OP_CURSOR) begin
      col_next = cur.pos_x;
      row_next = cur.pos_y;
    end else if (is_char) begin
      col_next = text_col + CURSOR_ADVANCE;
    end
  end

  // a glyph spans at most two pages: the one of its top row and of its bottom row
  assign gbits        = glyph_bits(cur.char_code);
  assign gsel         = 3'(GLYPH_COLS - 1) - col_cnt;
  assign gcol         = gbits[gsel*8 +: 8];
  assign text_row_end = text_row + 8'(GLYPH_ROWS - 1);
  assign char_page    = pass_q ? text_row_end[7:3] : text_row[7:3];

  always_comb begin
    logic [7:0] row_y;
    char_mask = '0;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      row_y = text_row + 8'(r);
      if (gcol[r] && row_y < PANEL_HEIGHT && row_y[7:3] == char_page) begin
        char_mask[row_y[2:0]] = 1'b1;
      end
    end
  end

  always_comb begin
    if (is_pixel) begin
      step_x     = cur.pos_x;
      step_page  = cur.pos_y[7:3];
      step_mask  = 8'd1 << cur.pos_y[2:0];
      step_valid = (cur.pos_x < PANEL_WIDTH) && (cur.pos_y < PANEL_HEIGHT);
    end else begin
      step_x     = text_col + 8'(col_cnt);
      step_page  = char_page;
      step_mask  = char_mask;
      step_valid = (step_x < PANEL_WIDTH) && (char_mask != 8'd0);
    end
  end

  assign step_addr = ADDR_W'(step_x) + ADDR_W'(step_page * PANEL_WIDTH);
  assign rmw_data  = (is_pixel && !cur.pixel_color) ? (ram_rdata & ~step_mask)
                                                     : (ram_rdata | step_mask);
  assign rd_in_range = ({1'b0, cur.byte_index} < 11'(STORE_USED));

  assign ram_we    = cmd.sweep_wr || cmd.step_wr;
  assign ram_waddr = cmd.sweep_wr ? sweep_cnt : step_addr;
  assign ram_wdata = cmd.sweep_wr ? (cmd.sweep_fill ? BYTE_SET : BYTE_CLEAR) : rmw_data;
  assign ram_re    = cmd.step_rd || cmd.read_rd;
  assign ram_raddr = cmd.read_rd ? cur.byte_index[ADDR_W-1:0] : step_addr;

  mfbtd_ram #(
    .WIDTH (8),
    .DEPTH (STORE_USED)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign status.op         = cur.operation;
  assign status.step_valid = step_valid;
  assign status.step_last  = !is_char || (col_cnt == 3'(GLYPH_COLS - 1) && pass_q);
  assign status.sweep_last = sweep_last;

endmodule

`default_nettype wire

// ===== tb/mono_framebuffer_text_draw_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_text_draw_tb
// Self-checking bench for the page framebuffer text draw block. A driver
// feeds command transactions from a queue, with random gaps. A monitor
// mirrors the framebuffer, cursor and 5x7 font to predict each result and
// checks it field by field. The receiver stalls at random, including one
// long hold that backs the block up.
// ----------------------------------------------------------------------------
module mono_framebuffer_text_draw_tb;
  import mfbtd_pkg::*;

  localparam int PANEL_W      = 128;
  localparam int PANEL_H      = 64;
  localparam int STORE_BYTES  = PANEL_W * ((PANEL_H + 7) / 8);
  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 1500;
  localparam int QUIET_TAIL   = 150;
  localparam int DRAIN_EVERY  = 300;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 150;
  localparam int TAIL_CYCLES  = 50;
  localparam int CYCLE_LIMIT  = 600000;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int GLYPHS = 24;
  localparam bit [8*GLYPHS-1:0] GLYPH_CODES = " ACDVm:0123456789EMOPRST";
  localparam bit [40*GLYPHS-1:0] GLYPH_COLS = {
    40'h0000000000, 40'h7E1111117E, 40'h3E41414122, 40'h7F4141221C,
    40'h1F2040201F, 40'h7C04180478, 40'h0036360000, 40'h3E5149453E,
    40'h00427F4000, 40'h4261514946, 40'h2141454B31, 40'h1814127F10,
    40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h7F49494941, 40'h7F020C027F, 40'h3E4141413E,
    40'h7F09090906, 40'h7F09192946, 40'h4649494931, 40'h01017F0101
  };

  typedef struct {
    bit       drain_first;
    in_item_t cmd;
  } pending_t;

  logic      clk          = 1'b0;
  logic      rst          = 1'b1;
  logic      item_valid   = 1'b0;
  logic      item_stall;
  in_item_t  item         = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_item_t result;

  pending_t  pending_q[$];
  out_item_t expected_q[$];
  logic [7:0] frame_mirror [STORE_BYTES];
  logic [7:0] text_x;
  logic [7:0] text_y;

  int items_accepted = 0;
  int results_seen   = 0;
  int total_items    = 0;
  int fail_count     = 0;
  int cycle_count    = 0;

  mono_framebuffer_text_draw #(
    .PANEL_WIDTH  (PANEL_W),
    .PANEL_HEIGHT (PANEL_H)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic [7:0] glyph_code(input int slot);
    return GLYPH_CODES[(GLYPHS - 1 - slot) * 8 +: 8];
  endfunction

  function automatic int glyph_slot(input logic [7:0] code);
    for (int i = 1; i < GLYPHS; i++) begin
      if (glyph_code(i) == code) return i;
    end
    return 0;
  endfunction

  function automatic void put_dot(input logic [7:0] x, input logic [7:0] y,
                                  input logic lit);
    int addr;
    if (x >= PANEL_W || y >= PANEL_H) return;
    addr = x + (y / 8) * PANEL_W;
    if (addr >= STORE_BYTES) return;
    frame_mirror[addr][y % 8] = lit;
  endfunction

  function automatic out_item_t apply_cmd(input in_item_t cmd);
    out_item_t res;
    int slot;
    logic [7:0] column;
    res = '0;
    case (cmd.operation)
      OP_PIXEL: put_dot(cmd.pos_x, cmd.pos_y, cmd.pixel_color);
      OP_CURSOR: begin
        text_x = cmd.pos_x;
        text_y = cmd.pos_y;
      end
      OP_CHAR: begin
        slot = glyph_slot(cmd.char_code);
        for (int c = 0; c < 5; c++) begin
          column = GLYPH_COLS[(GLYPHS - 1 - slot) * 40 + (4 - c) * 8 +: 8];
          for (int r = 0; r < 7; r++) begin
            if (column[r]) put_dot(text_x + 8'(c), text_y + 8'(r), 1'b1);
          end
        end
        text_x = text_x + CURSOR_ADVANCE;
      end
      OP_CLEAR: foreach (frame_mirror[i]) frame_mirror[i] = BYTE_CLEAR;
      OP_FILL:  foreach (frame_mirror[i]) frame_mirror[i] = BYTE_SET;
      OP_READ: begin
        if (cmd.byte_index < STORE_BYTES) res.read_data = frame_mirror[cmd.byte_index];
      end
      default: ;
    endcase
    res.cursor_col = text_x;
    res.cursor_row = text_y;
    return res;
  endfunction

  function automatic bit idle_ok();
    return (items_accepted < total_items - QUIET_TAIL) && ((items_accepted / 200) % 4 != 3);
  endfunction

  task automatic add_cmd(input logic [2:0] op, input int x, input int y, input int color,
                         input int code, input int idx, input bit drain);
    pending_t p;
    p.drain_first         = drain;
    p.cmd.operation       = op;
    p.cmd.pos_x           = x[7:0];
    p.cmd.pos_y           = y[7:0];
    p.cmd.pixel_color     = color[0];
    p.cmd.char_code       = code[7:0];
    p.cmd.byte_index      = idx[9:0];
    pending_q.push_back(p);
  endtask

  // driver
  always @(posedge clk) begin : driver
    int gap;
    if (rst) begin
      item_valid <= 1'b0;
      gap = 0;
    end else if (!item_valid || !item_stall) begin
      if (gap > 0) begin
        gap--;
        item_valid <= 1'b0;
      end else if (pending_q.size() == 0) begin
        item_valid <= 1'b0;
      end else if (pending_q[0].drain_first &&
                   (item_valid || results_seen != items_accepted)) begin
        item_valid <= 1'b0;
      end else if (idle_ok() && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 7) - 1;
        item_valid <= 1'b0;
      end else begin
        item       <= pending_q[0].cmd;
        item_valid <= 1'b1;
        pending_q.pop_front();
      end
    end
  end

  // receiver
  always @(posedge clk) begin : receiver
    int hold;
    bit long_done;
    if (rst) begin
      result_stall <= 1'b0;
      hold = 0;
      long_done = 1'b0;
    end else begin
      if (!long_done && items_accepted >= HOLD_AT) begin
        hold = HOLD_CYCLES;
        long_done = 1'b1;
      end else if (hold == 0 && idle_ok() && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 7);
      end
      if (hold > 0) begin
        hold--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // monitor: check results first, then predict newly accepted transactions
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          $error("result with none expected: %h", result);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (result.read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, result.read_data);
            fail_count++;
          end
          if (result.cursor_col !== want.cursor_col) begin
            $error("cursor_col: expected %0d, got %0d", want.cursor_col, result.cursor_col);
            fail_count++;
          end
          if (result.cursor_row !== want.cursor_row) begin
            $error("cursor_row: expected %0d, got %0d", want.cursor_row, result.cursor_row);
            fail_count++;
          end
        end
        results_seen <= results_seen + 1;
      end
      if (item_valid && !item_stall) begin
        expected_q.push_back(apply_cmd(item));
        items_accepted <= items_accepted + 1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("mono_framebuffer_text_draw verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int pick;
    int cx;
    int cy;
    int n;
    int next_drain;
    bit drain;
    foreach (frame_mirror[i]) frame_mirror[i] = BYTE_CLEAR;
    text_x = '0;
    text_y = '0;

    // directed: edges, clipping, wraps, unknown glyph, spare codes, clear/fill
    add_cmd(OP_READ,   0, 0, 0, 0, 0, 0);
    add_cmd(OP_READ,   255, 255, 1, 255, 1023, 0);
    add_cmd(OP_PIXEL,  0, 0, 1, 0, 0, 0);
    add_cmd(OP_PIXEL,  127, 63, 1, 0, 0, 0);
    add_cmd(OP_PIXEL,  128, 5, 1, 0, 0, 0);
    add_cmd(OP_PIXEL,  5, 64, 1, 0, 0, 0);
    add_cmd(OP_PIXEL,  255, 255, 1, 0, 0, 0);
    add_cmd(OP_READ,   0, 0, 0, 0, 1023, 0);
    add_cmd(OP_PIXEL,  0, 0, 0, 0, 0, 0);
    add_cmd(OP_READ,   0, 0, 0, 0, 0, 0);
    add_cmd(OP_CURSOR, 0, 0, 0, 0, 0, 0);
    add_cmd(OP_CHAR,   0, 0, 0, "A", 0, 0);
    add_cmd(OP_READ,   0, 0, 0, 0, 1, 0);
    add_cmd(OP_CURSOR, 254, 60, 0, 0, 0, 0);
    add_cmd(OP_CHAR,   0, 0, 0, "8", 0, 0);
    add_cmd(OP_READ,   0, 0, 0, 0, 7 * PANEL_W, 0);
    add_cmd(OP_CURSOR, 125, 3, 0, 0, 0, 0);
    add_cmd(OP_CHAR,   0, 0, 0, "M", 0, 0);
    add_cmd(OP_READ,   0, 0, 0, 0, PANEL_W + 125, 0);
    add_cmd(OP_CHAR,   0, 0, 0, 255, 0, 0);
    add_cmd(OP_SPARE_6, 200, 17, 1, 65, 300, 0);
    add_cmd(OP_SPARE_7, 33, 240, 0, 128, 512, 0);
    add_cmd(OP_FILL,   0, 0, 0, 0, 0, 0);
    add_cmd(OP_PIXEL,  10, 10, 0, 0, 0, 0);
    add_cmd(OP_READ,   0, 0, 0, 0, PANEL_W + 10, 0);
    add_cmd(OP_CLEAR,  0, 0, 0, 0, 700, 0);

    next_drain = pending_q.size();
    while (pending_q.size() < RANDOM_ITEMS + 26) begin
      drain = pending_q.size() >= next_drain;
      if (drain) next_drain += DRAIN_EVERY;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        cx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 127);
        cy = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 63);
        add_cmd(OP_CURSOR, cx, cy, $urandom, $urandom, $urandom, drain);
        n = $urandom_range(1, 6);
        repeat (n) begin
          add_cmd(OP_CHAR, $urandom, $urandom, $urandom,
                  ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255)
                                             : glyph_code($urandom_range(1, GLYPHS - 1)),
                  $urandom, 1'b0);
        end
        repeat ($urandom_range(1, 3)) begin
          add_cmd(OP_READ, $urandom, $urandom, $urandom, $urandom,
                  ((cy / 8 + $urandom_range(0, 1)) % 8) * PANEL_W +
                  (cx + $urandom_range(0, n * 6)) % PANEL_W, 1'b0);
        end
      end else if (pick < 60) begin
        repeat ($urandom_range(1, 4)) begin
          cx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 127);
          cy = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 63);
          add_cmd(OP_PIXEL, cx, cy, $urandom, $urandom, $urandom, drain);
          drain = 1'b0;
        end
        add_cmd(OP_READ, $urandom, $urandom, $urandom, $urandom,
                ((cy / 8) % 8) * PANEL_W + cx % PANEL_W, 1'b0);
      end else if (pick < 82) begin
        add_cmd(OP_READ, $urandom, $urandom, $urandom, $urandom,
                $urandom_range(0, 1023), drain);
      end else if (pick < 92) begin
        add_cmd(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom, $urandom,
                drain);
      end else if (pick < 99) begin
        repeat ($urandom_range(1, 3)) begin
          add_cmd(OP_CHAR, $urandom, $urandom, $urandom, $urandom_range(0, 255), $urandom,
                  drain);
          drain = 1'b0;
        end
      end else begin
        add_cmd($urandom_range(0, 1) ? OP_CLEAR : OP_FILL, $urandom, $urandom, $urandom,
                $urandom, $urandom, drain);
      end
    end
    total_items = pending_q.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || item_valid || items_accepted != results_seen)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("mono_framebuffer_text_draw verification clean");
    end else begin
      $display("mono_framebuffer_text_draw verification failed");
    end
    $finish;
  end

endmodule
